// ----- rtl/core/wdo_pkg.sv -----
// ----------------------------------------------------------------------------
// wdo_pkg
// Types, constants, microcode table and helpers for the wave disturbance
// oscillator.
// ----------------------------------------------------------------------------
package wdo_pkg;

   localparam int AXES        = 3;
   localparam int AXIS_W      = 2;
   localparam int STATE_W     = 32;
   localparam int NOISE_W     = 16;
   localparam int COEF_W      = 48;
   localparam int FIELD_W     = 16;
   localparam int DT_W        = 16;
   localparam int FORCE_W     = 48;
   localparam int ACC_W       = 38;
   localparam int MUL_W       = ACC_W + FIELD_W + 1;
   localparam int SUM_W       = MUL_W + 1;
   localparam int STEP_W      = 3;
   localparam int CSR_IDX_W   = 2;

   localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SURGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DT    = 2'd3;

   localparam logic [COEF_W-1:0] COEF_RESET = 48'd2147531951350;
   localparam logic [DT_W-1:0]   DT_RESET   = 16'd1311;

   typedef enum logic [1:0] {
      A_POS,
      A_VEL,
      A_ACC
   } a_sel_type;

   typedef enum logic [1:0] {
      B_STIFF,
      B_DAMP,
      B_DT,
      B_GAIN
   } b_sel_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_12,
      SH_16
   } shift_type;

   typedef enum logic [2:0] {
      OP_ACC_INIT,
      OP_ACC_SUB,
      OP_POS,
      OP_VEL,
      OP_FORCE
   } op_type;

   typedef enum logic {
      SEQ_NEXT,
      SEQ_LOOP
   } seq_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      shift_type shift;
      op_type    op;
      seq_type   seq;
   } ucode_type;

   // per-axis program, run once for each axis
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      case (step)
         3'd0:    uc = '{A_POS, B_STIFF, SH_12,   OP_ACC_INIT, SEQ_NEXT};
         3'd1:    uc = '{A_VEL, B_DAMP,  SH_12,   OP_ACC_SUB,  SEQ_NEXT};
         3'd2:    uc = '{A_VEL, B_DT,    SH_16,   OP_POS,      SEQ_NEXT};
         3'd3:    uc = '{A_ACC, B_DT,    SH_16,   OP_VEL,      SEQ_NEXT};
         3'd4:    uc = '{A_VEL, B_GAIN,  SH_NONE, OP_FORCE,    SEQ_LOOP};
         default: uc = '{A_POS, B_STIFF, SH_NONE, OP_FORCE,    SEQ_LOOP};
      endcase
      return uc;
   endfunction

   function automatic logic [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(signed'({1'b0, {(STATE_W-1){1'b1}}}));
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return v[STATE_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/core/wave_disturbance_oscillator.sv -----
// ----------------------------------------------------------------------------
// wave_disturbance_oscillator
// Three-axis damped second-order wave response, forward Euler per request,
// run by a microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// sequence: 5 microcode steps per axis over 3 axes, one multiply per step on the
//   shared multiplier; rsp_tvalid is registered after the last step
// requests: a new request is taken while idle or in the last step, and the
//   final step holds while the previous response is not taken
// reset: synchronous; state cleared to zero, coefficients to their defaults
module wave_disturbance_oscillator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // noise_surge [15:0], noise_sway [31:16], noise_yaw [47:32]
   input  logic [47:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_surge [47:0], force_sway [95:48], torque_yaw [143:96]
   output logic [143:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [wdo_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wdo_pkg::COEF_W-1:0]    csr_wdata
);
   import wdo_pkg::*;

   logic [COEF_W-1:0]        coef_ff [AXES];
   logic [DT_W-1:0]          dt_ff;
   logic signed [STATE_W-1:0] pos_ff [AXES];
   logic signed [STATE_W-1:0] vel_ff [AXES];
   logic signed [NOISE_W-1:0] noise_ff [AXES];
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [FORCE_W-1:0]       force_ff [AXES-1];
   logic                     busy_ff, busy_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [AXIS_W-1:0]        axis_ff, axis_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [143:0]             rsp_data_ff;

   ucode_type                uc;
   logic [COEF_W-1:0]        coef;
   logic signed [ACC_W-1:0]  mul_a;
   logic [FIELD_W-1:0]       mul_b;
   logic signed [MUL_W-1:0]  product;
   logic signed [MUL_W-1:0]  shifted;
   logic signed [SUM_W-1:0]  state_sum;
   logic signed [STATE_W-1:0] state_old;
   logic                     req_fire;
   logic                     last_step;
   logic                     stall;
   logic                     done_go;
   logic                     step_go;

   assign uc   = ucode_rom(step_ff);
   assign coef = coef_ff[axis_ff];

   // operand selection
   always_comb begin
      case (uc.a_sel)
         A_POS:   mul_a = ACC_W'(pos_ff[axis_ff]);
         A_VEL:   mul_a = ACC_W'(vel_ff[axis_ff]);
         A_ACC:   mul_a = acc_ff;
         default: mul_a = acc_ff;
      endcase
      case (uc.b_sel)
         B_STIFF: mul_b = coef[15:0];
         B_DAMP:  mul_b = coef[31:16];
         B_DT:    mul_b = dt_ff;
         B_GAIN:  mul_b = coef[47:32];
         default: mul_b = coef[47:32];
      endcase
   end

   assign product = MUL_W'(mul_a) * MUL_W'(signed'({1'b0, mul_b}));

   // arithmetic shifts give the floor rounding
   always_comb begin
      case (uc.shift)
         SH_12:   shifted = product >>> 12;
         SH_16:   shifted = product >>> 16;
         SH_NONE: shifted = product;
         default: shifted = product;
      endcase
   end

   assign state_old = (uc.op == OP_POS) ? pos_ff[axis_ff] : vel_ff[axis_ff];
   assign state_sum = SUM_W'(state_old) + SUM_W'(shifted);

   assign last_step = (uc.seq == SEQ_LOOP) && (axis_ff == AXIS_LAST);
   assign stall     = busy_ff && last_step && rsp_valid_ff && !rsp_tready;
   assign step_go   = busy_ff && !stall;
   assign done_go   = step_go && last_step;
   assign req_tready = !busy_ff || done_go;
   assign req_fire  = req_tvalid && req_tready;

   always_comb begin
      acc_in = acc_ff;
      case (uc.op)
         OP_ACC_INIT: acc_in = ACC_W'(noise_ff[axis_ff]) * ACC_W'(16) - shifted[ACC_W-1:0];
         OP_ACC_SUB:  acc_in = acc_ff - shifted[ACC_W-1:0];
         OP_POS,
         OP_VEL,
         OP_FORCE:    acc_in = acc_ff;
         default:     acc_in = acc_ff;
      endcase
   end

   // sequencer
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      axis_in = axis_ff;
      if (step_go) begin
         if (uc.seq == SEQ_LOOP) begin
            step_in = '0;
            if (axis_ff == AXIS_LAST) begin
               axis_in = '0;
               busy_in = 1'b0;
            end else begin
               axis_in = axis_ff + AXIS_W'(1);
            end
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration and oscillator state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            coef_ff[i] <= COEF_RESET;
            pos_ff[i]  <= '0;
            vel_ff[i]  <= '0;
         end
         dt_ff <= DT_RESET;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SURGE: coef_ff[0] <= csr_wdata;
               CSR_SWAY:  coef_ff[1] <= csr_wdata;
               CSR_YAW:   coef_ff[2] <= csr_wdata;
               CSR_DT:    dt_ff      <= csr_wdata[DT_W-1:0];
               default:   dt_ff      <= dt_ff;
            endcase
         end
         if (step_go && uc.op == OP_POS) begin
            pos_ff[axis_ff] <= sat_state(state_sum);
         end
         if (step_go && uc.op == OP_VEL) begin
            vel_ff[axis_ff] <= sat_state(state_sum);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         noise_ff[0] <= req_tdata[15:0];
         noise_ff[1] <= req_tdata[31:16];
         noise_ff[2] <= req_tdata[47:32];
      end
      if (step_go) begin
         acc_ff <= acc_in;
      end
      // gain times new velocity always fits in 48 bits
      if (step_go && uc.op == OP_FORCE && !last_step) begin
         force_ff[axis_ff[0]] <= shifted[FORCE_W-1:0];
      end
      if (done_go) begin
         rsp_data_ff <= {shifted[FORCE_W-1:0], force_ff[1], force_ff[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_LAST && axis_ff <= AXIS_LAST)
      else $error("sequencer out of program range");

   a_idle_home: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (step_ff == '0 && axis_ff == '0))
      else $error("idle sequencer not at program start");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff)
      else $error("request accepted without starting the program");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(busy_ff))
      else $error("response raised without a running program");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> (step_ff == $past(step_ff) && axis_ff == $past(axis_ff)))
      else $error("sequencer moved while the output was blocked");

endmodule
